// ----- hdl/alm_pkg.sv -----
// Shared types, constants and helpers of the audio level meter.
// Depends on nothing; the front end, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

    localparam int ALM_MAX_CHANNELS = 8;
    localparam int ALM_QUEUE_DEPTH  = 4;
    localparam int ALM_ADDR_W       = 5;

    localparam logic [16:0] ALM_Q16_ONE = 17'h10000;

    // Register indexes, byte address 4 * index.
    localparam logic [2:0] ALM_REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [2:0] ALM_REG_PEAK_FALL      = 3'd1;
    localparam logic [2:0] ALM_REG_HOLD_FALL      = 3'd2;
    localparam logic [2:0] ALM_REG_RMS_ALPHA      = 3'd3;
    localparam logic [2:0] ALM_REG_HOLD_SAMPLES   = 3'd4;
    localparam logic [2:0] ALM_REG_OVER_THRESHOLD = 3'd5;

    typedef struct packed {
        logic               func;
        logic signed [23:0] sample;
    } alm_in_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [23:0] peak_level;
        logic [23:0] hold_level;
        logic [46:0] ms_level;
        logic        over_flag;
    } alm_out_t;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [16:0] peak_fall;
        logic [16:0] hold_fall;
        logic [16:0] rms_alpha;
        logic [23:0] hold_samples;
        logic [23:0] over_threshold;
    } alm_cfg_t;

    typedef enum logic [2:0] {
        ALM_IDLE,
        ALM_SQ,
        ALM_PEAK,
        ALM_DLO,
        ALM_DHI,
        ALM_HOLD,
        ALM_WRITE
    } alm_state_t;

    function automatic logic [16:0] alm_sat_q16(input logic [16:0] v);
        return (v > ALM_Q16_ONE) ? ALM_Q16_ONE : v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/alm_front.sv -----
// Front end of the audio level meter: accepts input words, assigns the channel,
// takes the sample magnitude and pushes a queue entry. Uses alm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alm_front
    import alm_pkg::*;
#(
    parameter int  MAX_CHANNELS = ALM_MAX_CHANNELS,
    localparam int CHAN_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int ENTRY_W      = CHAN_W + 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire alm_in_t            in_data,
    input  wire logic [3:0]         channel_count,
    input  wire logic               full,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data
);

    logic [CHAN_W-1:0] pos_reg;
    logic [CHAN_W-1:0] pos_next;
    logic [4:0]        count_raw;
    logic [4:0]        count_eff;
    logic [4:0]        pos_wide;
    logic [4:0]        inc_wide;
    logic [CHAN_W-1:0] chan;
    logic [23:0]       raw;
    logic [23:0]       mag;
    logic              accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        count_raw = {1'b0, channel_count};
        if (count_raw == 5'd0)
        begin
            count_eff = 5'd1;
        end
        else if (count_raw > 5'(MAX_CHANNELS))
        begin
            count_eff = 5'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = count_raw;
        end

        // A position left beyond a lowered channel count restarts at channel 0.
        pos_wide = 5'(pos_reg);
        if (pos_wide >= count_eff)
        begin
            pos_wide = 5'd0;
        end
        chan     = pos_wide[CHAN_W-1:0];
        inc_wide = pos_wide + 5'd1;

        pos_next = pos_reg;
        if (accept)
        begin
            if (in_data.func || (inc_wide >= count_eff))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = inc_wide[CHAN_W-1:0];
            end
        end
    end

    always_comb
    begin
        raw = in_data.sample;
        mag = raw[23] ? (~raw + 24'd1) : raw;
    end

    assign push      = accept;
    assign push_data = {in_data.func, chan, mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/alm_queue.sv -----
// Short first-in first-out queue between the front and back ends of the meter.
// Register based; depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module alm_queue
#(
    parameter int  WIDTH = 28,
    parameter int  DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/alm_back.sv -----
// Back end of the audio level meter: per-channel state and a sequencer around
// one shared 24 x 24 multiplier, with the result output register. Uses alm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alm_back
    import alm_pkg::*;
#(
    parameter int  MAX_CHANNELS = ALM_MAX_CHANNELS,
    localparam int CHAN_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int ENTRY_W      = CHAN_W + 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire alm_cfg_t           cfg,
    input  wire logic               empty,
    input  wire logic [ENTRY_W-1:0] head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output alm_out_t                out_data
);

    alm_state_t state_reg;
    alm_state_t state_next;

    logic [23:0] peak_store_reg [MAX_CHANNELS];
    logic [23:0] hold_store_reg [MAX_CHANNELS];
    logic [23:0] hold_count_reg [MAX_CHANNELS];
    logic [46:0] ms_store_reg   [MAX_CHANNELS];
    logic        over_store_reg [MAX_CHANNELS];

    logic              head_func;
    logic [CHAN_W-1:0] head_chan;
    logic [23:0]       head_mag;

    logic [CHAN_W-1:0] chan_reg;
    logic [23:0]       mag_reg;
    logic [47:0]       prod_reg;
    logic [46:0]       diff_reg;
    logic              neg_reg;
    logic [23:0]       peak_new_reg;
    logic [24:0]       lo_reg;
    logic [46:0]       step_reg;
    logic              out_valid_reg;
    alm_out_t          out_data_reg;

    logic [23:0]       mul_a;
    logic [23:0]       mul_b;
    logic [47:0]       mul_p;
    logic              write_en;
    logic              out_free;
    logic [16:0]       peak_mult;
    logic [16:0]       hold_mult;
    logic [16:0]       alpha;

    logic [46:0]       sq;
    logic [46:0]       ms_old;
    logic [23:0]       peak_dec;
    logic [23:0]       hold_old;
    logic [23:0]       cnt_old;
    logic [23:0]       hold_new;
    logic [23:0]       cnt_new;
    logic [46:0]       ms_new;
    logic              over_new;
    logic [CHAN_W+2:0] chan_ext;

    assign {head_func, head_chan, head_mag} = head;

    assign peak_mult = alm_sat_q16(cfg.peak_fall);
    assign hold_mult = alm_sat_q16(cfg.hold_fall);
    assign alpha     = alm_sat_q16(cfg.rms_alpha);
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_p     = 48'(mul_a) * 48'(mul_b);

    // Sequencer outputs: multiplier operands, queue pop and state write-back.
    always_comb
    begin
        pop      = 1'b0;
        write_en = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ALM_IDLE:
            begin
                pop = !empty;
            end
            ALM_SQ:
            begin
                mul_a = mag_reg;
                mul_b = mag_reg;
            end
            ALM_PEAK:
            begin
                mul_a = peak_store_reg[chan_reg];
                mul_b = {7'd0, peak_mult};
            end
            ALM_DLO:
            begin
                mul_a = diff_reg[23:0];
                mul_b = {7'd0, alpha};
            end
            ALM_DHI:
            begin
                mul_a = {1'b0, diff_reg[46:24]};
                mul_b = {7'd0, alpha};
            end
            ALM_HOLD:
            begin
                mul_a = hold_store_reg[chan_reg];
                mul_b = {7'd0, hold_mult};
            end
            ALM_WRITE:
            begin
                write_en = out_free;
                pop      = out_free && !empty;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ALM_IDLE:
            begin
                if (!empty && !head_func)
                begin
                    state_next = ALM_SQ;
                end
            end
            ALM_SQ:    state_next = ALM_PEAK;
            ALM_PEAK:  state_next = ALM_DLO;
            ALM_DLO:   state_next = ALM_DHI;
            ALM_DHI:   state_next = ALM_HOLD;
            ALM_HOLD:  state_next = ALM_WRITE;
            ALM_WRITE:
            begin
                if (out_free)
                begin
                    state_next = (!empty && !head_func) ? ALM_SQ : ALM_IDLE;
                end
            end
            default:   state_next = ALM_IDLE;
        endcase
    end

    always_comb
    begin
        sq       = prod_reg[46:0];
        ms_old   = ms_store_reg[chan_reg];
        peak_dec = prod_reg[39:16];
        hold_old = hold_store_reg[chan_reg];
        cnt_old  = hold_count_reg[chan_reg];

        // In write-back the product register holds the decayed hold level.
        if (peak_new_reg >= hold_old)
        begin
            hold_new = peak_new_reg;
            cnt_new  = '0;
        end
        else if (cnt_old < cfg.hold_samples)
        begin
            hold_new = hold_old;
            cnt_new  = cnt_old + 24'd1;
        end
        else
        begin
            hold_new = prod_reg[39:16];
            cnt_new  = cnt_old;
        end

        ms_new   = neg_reg ? (ms_old - step_reg) : (ms_old + step_reg);
        over_new = over_store_reg[chan_reg] || (mag_reg >= cfg.over_threshold);
        chan_ext = {3'b000, chan_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ALM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (write_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The averaging step is split into the low 24 bits and high 23 bits of the difference:
    // step = (high * alpha) << 8 plus (low * alpha) >> 16, which is exact.
    always_ff @(posedge clk)
    begin
        if ((state_reg != ALM_IDLE) && (state_reg != ALM_WRITE))
        begin
            prod_reg <= mul_p;
        end
        if (pop)
        begin
            chan_reg <= head_chan;
            mag_reg  <= head_mag;
        end
        if (state_reg == ALM_PEAK)
        begin
            neg_reg  <= (sq < ms_old);
            diff_reg <= (sq >= ms_old) ? (sq - ms_old) : (ms_old - sq);
        end
        if (state_reg == ALM_DLO)
        begin
            peak_new_reg <= (mag_reg > peak_dec) ? mag_reg : peak_dec;
        end
        if (state_reg == ALM_DHI)
        begin
            lo_reg <= prod_reg[40:16];
        end
        if (state_reg == ALM_HOLD)
        begin
            step_reg <= {prod_reg[38:0], 8'd0} + {22'd0, lo_reg};
        end
        if (write_en)
        begin
            out_data_reg.channel    <= chan_ext[2:0];
            out_data_reg.peak_level <= peak_new_reg;
            out_data_reg.hold_level <= hold_new;
            out_data_reg.ms_level   <= ms_new;
            out_data_reg.over_flag  <= over_new;
        end
    end

    // A clear word popped in the write-back cycle comes after that sample,
    // so it takes priority over the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                peak_store_reg[i] <= '0;
                hold_store_reg[i] <= '0;
                hold_count_reg[i] <= '0;
                ms_store_reg[i]   <= '0;
                over_store_reg[i] <= 1'b0;
            end
        end
        else
        begin
            priority if (pop && head_func)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    peak_store_reg[i] <= '0;
                    hold_store_reg[i] <= '0;
                    hold_count_reg[i] <= '0;
                    ms_store_reg[i]   <= '0;
                    over_store_reg[i] <= 1'b0;
                end
            end
            else if (write_en)
            begin
                peak_store_reg[chan_reg] <= peak_new_reg;
                hold_store_reg[chan_reg] <= hold_new;
                hold_count_reg[chan_reg] <= cnt_new;
                ms_store_reg[chan_reg]   <= ms_new;
                over_store_reg[chan_reg] <= over_new;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hdl/audio_level_meter_top.sv -----
// Top level of the audio level meter: configuration registers on the APB port,
// front end, queue and back end. Uses alm_pkg, alm_front, alm_queue, alm_back.
//
//   Channel   Direction  Handshake                 Word
//   in        input      in_valid / in_stall       alm_in_t  (func, sample)
//   out       output     out_valid / out_stall     alm_out_t (channel, levels, flag)
//   config    input      psel/penable/pwrite/pready 6 registers at 4 * index
//
// A sample word holds the back end through SQ, PEAK, DLO, DHI, HOLD and WRITE:
// the one shared 24 x 24 multiplier forms five products per sample, then write-back.
// A clear word is popped in idle or write-back, starts no sequence and zeroes all channel state.
// The front takes one word per cycle while the queue has room.
// Reset zeroes all channel state at once; no clearing pass follows.
// A stalled result holds the back end in write-back; the queue then fills.
`timescale 1ns / 1ps
`default_nettype none

module audio_level_meter_top
    import alm_pkg::*;
#(
    parameter int  MAX_CHANNELS = ALM_MAX_CHANNELS,
    parameter int  QUEUE_DEPTH  = ALM_QUEUE_DEPTH,
    localparam int CHAN_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int ENTRY_W      = CHAN_W + 25
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire alm_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output alm_out_t                   out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ALM_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    alm_cfg_t           cfg_reg;
    logic [2:0]         reg_idx;
    logic               cfg_write;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic               full;
    logic               empty;
    logic [ENTRY_W-1:0] head;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ALM_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count  <= 4'd2;
            cfg_reg.peak_fall      <= ALM_Q16_ONE;
            cfg_reg.hold_fall      <= ALM_Q16_ONE;
            cfg_reg.rms_alpha      <= ALM_Q16_ONE;
            cfg_reg.hold_samples   <= 24'd0;
            cfg_reg.over_threshold <= 24'h800000;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                ALM_REG_CHANNEL_COUNT:  cfg_reg.channel_count  <= pwdata[3:0];
                ALM_REG_PEAK_FALL:      cfg_reg.peak_fall      <= pwdata[16:0];
                ALM_REG_HOLD_FALL:      cfg_reg.hold_fall      <= pwdata[16:0];
                ALM_REG_RMS_ALPHA:      cfg_reg.rms_alpha      <= pwdata[16:0];
                ALM_REG_HOLD_SAMPLES:   cfg_reg.hold_samples   <= pwdata[23:0];
                ALM_REG_OVER_THRESHOLD: cfg_reg.over_threshold <= pwdata[23:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ALM_REG_CHANNEL_COUNT:  prdata = {28'd0, cfg_reg.channel_count};
            ALM_REG_PEAK_FALL:      prdata = {15'd0, cfg_reg.peak_fall};
            ALM_REG_HOLD_FALL:      prdata = {15'd0, cfg_reg.hold_fall};
            ALM_REG_RMS_ALPHA:      prdata = {15'd0, cfg_reg.rms_alpha};
            ALM_REG_HOLD_SAMPLES:   prdata = {8'd0, cfg_reg.hold_samples};
            ALM_REG_OVER_THRESHOLD: prdata = {8'd0, cfg_reg.over_threshold};
            default:                prdata = 32'd0;
        endcase
    end

    alm_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .channel_count (cfg_reg.channel_count),
        .full          (full),
        .push          (push),
        .push_data     (push_data)
    );

    alm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    alm_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
